/* hdl/assert_macros.svh */
// assertion helpers for the reentry guard stack
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RGS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define RGS_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define RGS_ASSERT(label, prop)
`define RGS_NEVER(label, expr)
`endif
`endif

/* hdl/rgs_pkg.sv */
package rgs_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int ID_WIDTH_DEF    = 32;

  localparam int IDENT_W     = 32;
  localparam int KIND_W      = 2;
  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 3;
  localparam int DEPTH_OUT_W = 6;

  localparam logic [REQ_W-1:0] REQ_ENTER = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LEAVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CYCLE    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [KIND_W-1:0]  query_kind;
    logic [IDENT_W-1:0] primary_ident;
    logic [IDENT_W-1:0] secondary_ident;
    logic [IDENT_W-1:0] type_ident;
    logic [IDENT_W-1:0] name_ident;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic                   entered;
    logic [DEPTH_OUT_W-1:0] stack_depth;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

/* hdl/rgs_req_if.sv */
interface rgs_req_if import rgs_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/rgs_rsp_if.sv */
interface rgs_rsp_if import rgs_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/rgs_ctrl.sv */
module rgs_ctrl import rgs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // no transfer while reset is held
  assign req_ready = (state == S_IDLE) && !rst;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid && req_ready) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        // wait until the result register is free
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hdl/rgs_datapath.sv */
`include "assert_macros.svh"

module rgs_datapath import rgs_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  req_t            req_data,
  input  cmd_t            cmd,
  output stat_t           stat,
  rgs_rsp_if.source       rsp
);

  localparam int IDX_W   = $clog2(STACK_DEPTH);
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int KEEP_W  = (ID_WIDTH < IDENT_W) ? ID_WIDTH : IDENT_W;
  localparam int ENTRY_W = KIND_W + 4 * KEEP_W;
  localparam logic [CNT_W-1:0] DEPTH_MAX = CNT_W'(STACK_DEPTH);

  logic [ENTRY_W-1:0] mem [STACK_DEPTH];

  logic [ENTRY_W-1:0] key;
  logic [REQ_W-1:0]   req_code;
  logic [CNT_W-1:0]   fill;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   scan_end;
  logic               pend;
  logic               hit;
  logic [ENTRY_W-1:0] rd_data;
  logic               out_valid;
  rsp_t               out_data;

  logic [ENTRY_W-1:0] key_in;
  logic [CNT_W-1:0]   scan_lo;
  logic               issue;
  logic               push;
  logic [CNT_W-1:0]   fill_next;
  logic [STATUS_W-1:0] status_next;
  logic [CNT_W+DEPTH_OUT_W-1:0] depth_ext;

  assign key_in = {req_data.query_kind,
                   req_data.primary_ident[KEEP_W-1:0],
                   req_data.secondary_ident[KEEP_W-1:0],
                   req_data.type_ident[KEEP_W-1:0],
                   req_data.name_ident[KEEP_W-1:0]};

  // enter scans the whole stack, leave only the top entry
  always_comb begin
    case (req_data.req_type)
      REQ_ENTER: scan_lo = '0;
      REQ_LEAVE: scan_lo = (fill == '0) ? '0 : fill - CNT_W'(1);
      default:   scan_lo = fill;
    endcase
  end

  assign issue = (idx != scan_end);

  assign stat.scan_done = !pend && !issue;
  assign stat.out_free  = !out_valid || rsp.ready;

  always_comb begin
    status_next = ST_OK;
    push        = 1'b0;
    fill_next   = fill;
    case (req_code)
      REQ_ENTER: begin
        if (hit) begin
          status_next = ST_CYCLE;
        end else if (fill == DEPTH_MAX) begin
          status_next = ST_FULL;
        end else begin
          push      = 1'b1;
          fill_next = fill + CNT_W'(1);
        end
      end
      REQ_LEAVE: begin
        if (fill == '0) begin
          status_next = ST_EMPTY;
        end else if (!hit) begin
          status_next = ST_MISMATCH;
        end else begin
          fill_next = fill - CNT_W'(1);
        end
      end
      REQ_CLEAR: begin
        fill_next = '0;
      end
      default: begin
        fill_next = fill;
      end
    endcase
  end

  assign depth_ext = {{DEPTH_OUT_W{1'b0}}, fill_next};

  // scan pipeline: read one entry per cycle, compare it the cycle after
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key      <= key_in;
      req_code <= req_data.req_type;
      idx      <= scan_lo;
      scan_end <= fill;
      hit      <= 1'b0;
    end else if (cmd.scan) begin
      if (issue) begin
        rd_data <= mem[idx[IDX_W-1:0]];
        idx     <= idx + CNT_W'(1);
      end
      if (pend && (rd_data == key)) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && push) begin
      mem[fill[IDX_W-1:0]] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data.status      <= status_next;
      out_data.entered     <= push;
      out_data.stack_depth <= depth_ext[DEPTH_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        fill <= fill_next;
      end
      if (cmd.load) begin
        pend <= 1'b0;
      end else if (cmd.scan) begin
        pend <= issue;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  `RGS_NEVER(a_fill_in_range, fill > DEPTH_MAX)
  `RGS_NEVER(a_scan_in_bounds, cmd.scan && (idx > scan_end))
  `RGS_NEVER(a_no_result_overwrite, cmd.commit && out_valid && !rsp.ready)
  `RGS_ASSERT(a_push_grows, cmd.commit && push |=> fill == $past(fill) + CNT_W'(1))

endmodule

/* hdl/reentry_guard_stack.sv */
// an enter reads every stack entry through the one-entry-per-cycle read port of the key
// memory, a leave only the top entry, a clear or unused code none
// throughput: one request at a time; the next transfer is taken the cycle after the result
// is written, even while that result still waits in the output register
// reset: synchronous, clears the fill count, the controller and the output valid;
// stack contents are not cleared
module reentry_guard_stack import rgs_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  rgs_req_if.sink   req,
  rgs_rsp_if.source rsp
);

  cmd_t  cmd;
  stat_t stat;

  rgs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rgs_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .req_data (req.data),
    .cmd      (cmd),
    .stat     (stat),
    .rsp      (rsp)
  );

endmodule
